FILE: rtl/odx_pkg.sv
package odx_pkg;

	// frame size limits
	localparam int MAX_WIDTH  = 256;
	localparam int MAX_HEIGHT = 256;

	// configuration register widths and reset values
	localparam int CFG_W       = 9;
	localparam int DIM_W       = 9;
	localparam int STEP_W      = 5;
	localparam int CFG_IDX_W   = 2;
	localparam logic [DIM_W-1:0]  WIDTH_RST  = DIM_W'(240);
	localparam logic [DIM_W-1:0]  HEIGHT_RST = DIM_W'(240);
	localparam logic [STEP_W-1:0] STEP_RST   = '0;

	// register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_FRAME_WIDTH  = 2'd0,
		REG_FRAME_HEIGHT = 2'd1,
		REG_BLEND_STEP   = 2'd2
	} cfg_reg_t;

	// counter and geometry widths
	localparam int ROW_BYTES_MAX = MAX_WIDTH / 8;
	localparam int COL_W  = (ROW_BYTES_MAX > 1) ? $clog2(ROW_BYTES_MAX) : 1;
	localparam int ROW_W  = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
	localparam int WMAX_W = $clog2(MAX_WIDTH + 1);
	localparam int HMAX_W = $clog2(MAX_HEIGHT + 1);
	localparam int WEXT_W = (WMAX_W > DIM_W) ? WMAX_W : DIM_W;
	localparam int HEXT_W = (HMAX_W > DIM_W) ? HMAX_W : DIM_W;

	// 4x4 bayer threshold for (x & 3, y & 3)
	function automatic logic [3:0] bayer_thr(input logic [1:0] y, input logic [1:0] x);
		logic [3:0] t;
		case ({y, x})
			4'd0:  t = 4'd0;
			4'd1:  t = 4'd8;
			4'd2:  t = 4'd2;
			4'd3:  t = 4'd10;
			4'd4:  t = 4'd12;
			4'd5:  t = 4'd4;
			4'd6:  t = 4'd14;
			4'd7:  t = 4'd6;
			4'd8:  t = 4'd3;
			4'd9:  t = 4'd11;
			4'd10: t = 4'd1;
			4'd11: t = 4'd9;
			4'd12: t = 4'd15;
			4'd13: t = 4'd7;
			4'd14: t = 4'd13;
			4'd15: t = 4'd5;
			default: t = 4'd0;
		endcase
		return t;
	endfunction

endpackage

FILE: rtl/ordered_dither_crossfade.sv
// Ordered-dither crossfade of two 1-bit-per-pixel frames.
// Slave stream: one beat per byte position, tdata carries the source byte
// and the target byte of the same position, packed MSB-first raster order.
// Master stream: one beat per slave beat, tdata is the blended byte (pixels
// past the frame width are zero), tlast marks the last byte of the frame.
// The block counts byte column and pixel row itself; after the beat with
// tlast both counters return to zero.
// Configuration: cfg_we writes cfg_data into register cfg_index
// (0 frame_width, 1 frame_height, 2 blend_step); write only while idle.
// A taken beat goes into the result register, which drives the master
// side. Throughput: one beat per cycle while m_axis_tready is high, set
// by the single result register; the slave side stays ready whenever
// that register is empty or is being drained in the same cycle.
// Stall: while m_axis_tready is low a held result keeps its value and
// s_axis_tready drops, so no beat is lost or repeated.
// Reset: arst_n clears the counters and the result valid flag, and loads
// width 240, height 240, blend step 0.
module ordered_dither_crossfade (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_axis_tvalid,
	output logic                          s_axis_tready,
	input  logic [15:0]                   s_axis_tdata,  // from_byte[7:0], to_byte[15:8]
	output logic                          m_axis_tvalid,
	input  logic                          m_axis_tready,
	output logic [7:0]                    m_axis_tdata,  // out_byte[7:0]
	output logic                          m_axis_tlast,
	input  logic                          cfg_we,
	input  logic [odx_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [odx_pkg::CFG_W-1:0]     cfg_data
);
	import odx_pkg::*;

	logic [DIM_W-1:0]  frame_width_q;
	logic [DIM_W-1:0]  frame_height_q;
	logic [STEP_W-1:0] blend_step_q;
	logic [COL_W-1:0]  byte_col_q;
	logic [ROW_W-1:0]  pixel_row_q;
	logic              out_valid_q;
	logic [7:0]        out_byte_q;
	logic              out_last_q;

	logic [7:0]        from_byte;
	logic [7:0]        to_byte;
	logic              in_beat;
	logic [WEXT_W-1:0] w_ext;
	logic [WEXT_W-1:0] w_clamp;
	logic [WEXT_W-1:0] last_col;
	logic [WEXT_W-1:0] col_ext;
	logic [WEXT_W-1:0] x_base;
	logic [HEXT_W-1:0] h_ext;
	logic [HEXT_W-1:0] h_clamp;
	logic [HEXT_W-1:0] row_ext;
	logic              col_end;
	logic              row_end;
	logic [7:0]        blend;

	assign from_byte = s_axis_tdata[7:0];
	assign to_byte   = s_axis_tdata[15:8];

	// handshake: take a beat when the result slot is free or draining
	assign s_axis_tready = !out_valid_q || m_axis_tready;
	assign in_beat       = s_axis_tvalid && s_axis_tready;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q  <= WIDTH_RST;
			frame_height_q <= HEIGHT_RST;
			blend_step_q   <= STEP_RST;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_FRAME_WIDTH:  frame_width_q  <= cfg_data[DIM_W-1:0];
				REG_FRAME_HEIGHT: frame_height_q <= cfg_data[DIM_W-1:0];
				REG_BLEND_STEP:   blend_step_q   <= cfg_data[STEP_W-1:0];
				default: ;
			endcase
		end
	end

	// clamped geometry and end-of-row / end-of-frame detection
	always_comb begin
		w_ext = WEXT_W'(frame_width_q);
		if (w_ext == '0)
			w_clamp = WEXT_W'(1);
		else if (w_ext > WEXT_W'(MAX_WIDTH))
			w_clamp = WEXT_W'(MAX_WIDTH);
		else
			w_clamp = w_ext;
		last_col = (w_clamp - WEXT_W'(1)) >> 3;
		col_ext  = WEXT_W'(byte_col_q);
		col_end  = col_ext >= last_col;
		x_base   = col_ext << 3;

		h_ext = HEXT_W'(frame_height_q);
		if (h_ext == '0)
			h_clamp = HEXT_W'(1);
		else if (h_ext > HEXT_W'(MAX_HEIGHT))
			h_clamp = HEXT_W'(MAX_HEIGHT);
		else
			h_clamp = h_ext;
		row_ext = HEXT_W'(pixel_row_q);
		row_end = row_ext >= (h_clamp - HEXT_W'(1));
	end

	// per-pixel dither select, bit 7 is the leftmost pixel
	always_comb begin
		for (int b = 0; b < 8; b++) begin
			if ((x_base + WEXT_W'(b)) >= w_clamp)
				blend[7-b] = 1'b0;
			else if ({1'b0, bayer_thr(row_ext[1:0], 2'(b))} < blend_step_q)
				blend[7-b] = to_byte[7-b];
			else
				blend[7-b] = from_byte[7-b];
		end
	end

	// byte column and pixel row counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_col_q  <= '0;
			pixel_row_q <= '0;
		end else if (in_beat) begin
			if (col_end) begin
				byte_col_q <= '0;
				if (row_end)
					pixel_row_q <= '0;
				else
					pixel_row_q <= pixel_row_q + ROW_W'(1);
			end else begin
				byte_col_q <= byte_col_q + COL_W'(1);
			end
		end
	end

	// result register valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (in_beat)
			out_valid_q <= 1'b1;
		else if (m_axis_tready)
			out_valid_q <= 1'b0;
	end

	// result payload
	always_ff @(posedge clk) begin
		if (in_beat) begin
			out_byte_q <= blend;
			out_last_q <= col_end && row_end;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_byte_q;
	assign m_axis_tlast  = out_last_q;

endmodule

FILE: verif/tb_ordered_dither_crossfade.sv
`timescale 1ns / 1ps

module tb_ordered_dither_crossfade;
	import odx_pkg::*;

	localparam int CYCLE_LIMIT   = 200000;
	localparam int HOLD_LEN      = 150;
	localparam int RANDOM_PHASES = 16;

	// 4x4 bayer matrix, entry for (y & 3, x & 3) in nibble (y & 3) * 4 + (x & 3)
	localparam logic [63:0] BAYER = 64'h5D7F_91B3_6E4C_A280;

	// one input beat: from_byte low, to_byte high
	typedef struct packed {
		logic [7:0] to_byte;
		logic [7:0] from_byte;
	} pixel_pair_t;

	typedef struct {
		logic [7:0] out_byte;
		logic       frame_last;
	} mixed_beat_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 s_axis_tvalid = 1'b0;
	logic                 s_axis_tready;
	logic [15:0]          s_axis_tdata = '0;  // from_byte[7:0], to_byte[15:8]
	logic                 m_axis_tvalid;
	logic                 m_axis_tready = 1'b0;
	logic [7:0]           m_axis_tdata;       // out_byte[7:0]
	logic                 m_axis_tlast;
	logic                 cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0]     cfg_data = '0;

	// predictor copy of the registers and the position counters
	logic [DIM_W-1:0]  geo_width = WIDTH_RST;
	logic [DIM_W-1:0]  geo_height = HEIGHT_RST;
	logic [STEP_W-1:0] fade_step = STEP_RST;
	int                col_pos = 0;
	int                row_pos = 0;

	pixel_pair_t pair_queue[$];
	mixed_beat_t mixed_due[$];

	int          src_gap_pct = 0;
	int          sink_stall_pct = 0;
	logic        sink_hold = 1'b0;
	event        hold_go;
	int          mismatch_cnt = 0;
	int unsigned cycle_cnt = 0;

	ordered_dither_crossfade dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	// 12 ns clock
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// zero dimension counts as one, oversize saturates
	function automatic int fit_dim(input int v, input int maxv);
		if (v == 0) return 1;
		if (v > maxv) return maxv;
		return v;
	endfunction

	// blend one byte position and advance the column and row counters
	function automatic mixed_beat_t dissolve_byte(input pixel_pair_t p);
		int          w;
		int          h;
		int          row_bytes;
		int          x;
		int          b;
		logic        col_end;
		logic        row_end;
		logic [3:0]  thr;
		mixed_beat_t r;
		w = fit_dim(int'(geo_width), MAX_WIDTH);
		h = fit_dim(int'(geo_height), MAX_HEIGHT);
		row_bytes = (w + 7) / 8;
		col_end = col_pos >= row_bytes - 1;
		row_end = row_pos >= h - 1;
		r.out_byte = '0;
		for (b = 0; b < 8; b++) begin
			x = col_pos * 8 + b;
			if (x < w) begin
				thr = BAYER[((row_pos & 3) * 4 + (x & 3)) * 4 +: 4];
				// differing pixels switch to the target once the step passes the threshold
				if (p.from_byte[7-b] != p.to_byte[7-b] && thr < fade_step)
					r.out_byte[7-b] = p.to_byte[7-b];
				else
					r.out_byte[7-b] = p.from_byte[7-b];
			end
		end
		r.frame_last = col_end && row_end;
		if (col_end) begin
			col_pos = 0;
			row_pos = row_end ? 0 : row_pos + 1;
		end else begin
			col_pos = col_pos + 1;
		end
		return r;
	endfunction

	function automatic void note_mismatch(input string msg);
		if (mismatch_cnt < 10)
			$display("mismatch at %0t: %s", $time, msg);
		mismatch_cnt++;
	endfunction

	// source side: predict accepted beats, offer the next pair
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_axis_tvalid && s_axis_tready)
				mixed_due.push_back(dissolve_byte(s_axis_tdata));
			if (!s_axis_tvalid || s_axis_tready) begin
				if (pair_queue.size() != 0 && $urandom_range(99) >= src_gap_pct) begin
					s_axis_tvalid <= 1'b1;
					s_axis_tdata <= pair_queue.pop_front();
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	// sink side: check each beat against the oldest prediction
	always @(posedge clk) begin
		mixed_beat_t want;
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready) begin
				if (mixed_due.size() == 0) begin
					note_mismatch($sformatf("beat %02h last %0b with none expected",
						m_axis_tdata, m_axis_tlast));
				end else begin
					want = mixed_due.pop_front();
					if (m_axis_tdata !== want.out_byte)
						note_mismatch($sformatf("out_byte expected %02h got %02h",
							want.out_byte, m_axis_tdata));
					if (m_axis_tlast !== want.frame_last)
						note_mismatch($sformatf("frame_last expected %0b got %0b",
							want.frame_last, m_axis_tlast));
				end
			end
			m_axis_tready <= !sink_hold && ($urandom_range(99) >= sink_stall_pct);
		end
	end

	// long receiver hold-off, counted here
	always begin
		@(hold_go);
		@(posedge clk);
		sink_hold <= 1'b1;
		repeat (HOLD_LEN) @(posedge clk);
		sink_hold <= 1'b0;
	end

	// watchdog
	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt == CYCLE_LIMIT) begin
			$display("tb_ordered_dither_crossfade failed");
			$finish;
		end
	end

	task automatic queue_pair(input logic [7:0] src, input logic [7:0] dst);
		pair_queue.push_back({dst, src});
	endtask

	// wait until every pair is sent and every beat has come back
	task automatic settle();
		@(negedge clk);
		while (pair_queue.size() != 0 || s_axis_tvalid || mixed_due.size() != 0)
			@(negedge clk);
		repeat (2) @(negedge clk);
	endtask

	task automatic write_reg(input cfg_reg_t idx, input logic [CFG_W-1:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		case (idx)
			REG_FRAME_WIDTH: geo_width = val[DIM_W-1:0];
			REG_FRAME_HEIGHT: geo_height = val[DIM_W-1:0];
			REG_BLEND_STEP: fade_step = val[STEP_W-1:0];
			default: ;
		endcase
	endtask

	task automatic set_geometry(input int w, input int h, input int s);
		write_reg(REG_FRAME_WIDTH, CFG_W'(w));
		write_reg(REG_FRAME_HEIGHT, CFG_W'(h));
		write_reg(REG_BLEND_STEP, CFG_W'(s));
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic set_idle(input int mode);
		case (mode % 4)
			0: begin src_gap_pct = 0; sink_stall_pct = 0; end
			1: begin src_gap_pct = 48; sink_stall_pct = 0; end
			2: begin src_gap_pct = 0; sink_stall_pct = 48; end
			default: begin src_gap_pct = 19; sink_stall_pct = 19; end
		endcase
	endtask

	// stimulus sequence
	initial begin
		int w;
		int h;
		int s;
		int n;
		int fbytes;
		logic [7:0] src;

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// reset geometry, all source kept
		queue_pair(8'h00, 8'hFF);
		queue_pair(8'hFF, 8'h00);
		queue_pair(8'hFF, 8'hFF);
		queue_pair(8'hAA, 8'h55);
		settle();

		// shrink mid-row to one byte per row, all target
		set_geometry(8, 2, 16);
		set_idle(1);
		queue_pair(8'h0F, 8'hF0);
		queue_pair(8'h00, 8'hFF);
		queue_pair(8'hFF, 8'h00);
		settle();

		// zero width and height act as a single pixel, step past 16
		set_geometry(0, 0, 31);
		set_idle(2);
		queue_pair(8'h00, 8'hFF);
		queue_pair(8'h7F, 8'h80);
		queue_pair(8'hFF, 8'h00);
		settle();

		// oversize dimensions saturate, half-way dissolve
		set_geometry(511, 300, 8);
		set_idle(3);
		queue_pair(8'h00, 8'hFF);
		queue_pair(8'hFF, 8'h00);
		queue_pair(8'h55, 8'hAA);
		queue_pair(8'hC3, 8'h3C);
		settle();

		// width not a byte multiple, tail pixels zeroed
		set_geometry(13, 3, 17);
		set_idle(0);
		repeat (6) queue_pair(8'hFF, 8'hFF);
		settle();

		// random geometries, mostly whole frames of random pixels
		for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
			case ($urandom_range(9))
				0: w = 0;
				1: w = $urandom_range(257, 511);
				2: w = 256;
				3: w = 1;
				default: w = $urandom_range(1, 40);
			endcase
			case ($urandom_range(9))
				0: h = 0;
				1: h = $urandom_range(257, 511);
				2: h = 256;
				default: h = $urandom_range(1, 6);
			endcase
			s = ($urandom_range(3) == 0) ? $urandom_range(17, 31) : $urandom_range(0, 16);
			set_geometry(w, h, s);
			set_idle(ph);
			fbytes = (fit_dim(w, MAX_WIDTH) + 7) / 8 * fit_dim(h, MAX_HEIGHT);
			n = (fbytes <= 48) ? fbytes * (48 / fbytes) : 48;
			// now and then a broken frame
			if ($urandom_range(4) == 0)
				n += $urandom_range(1, 7);
			for (int i = 0; i < n; i++) begin
				src = 8'($urandom_range(255));
				if ($urandom_range(3) == 0)
					queue_pair(src, ~src);
				else
					queue_pair(src, 8'($urandom_range(255)));
			end
			settle();
		end

		// receiver holds off while the sender keeps offering
		set_geometry(16, 4, 9);
		set_idle(0);
		-> hold_go;
		repeat (64) queue_pair(8'($urandom_range(255)), 8'($urandom_range(255)));
		settle();

		// let any stray beat show up
		repeat (8) @(posedge clk);
		if (mismatch_cnt == 0)
			$display("tb_ordered_dither_crossfade passed");
		else
			$display("tb_ordered_dither_crossfade failed");
		$finish;
	end

endmodule
